// File: rtl/md5bc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5bc_pkg
// Shared types, request codes and round tables for the MD5 block compressor.
// ----------------------------------------------------------------------------
package md5bc_pkg;

    // Request function codes
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_WORD = 2'd1;
    localparam logic [1:0] FUNC_ZERO = 2'd2;

    // Standard MD5 initial chaining value
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] word;
        logic [1:0]  word_slot;
    } item_t;

    typedef struct packed {
        logic [63:0] digest_low;
        logic [63:0] digest_high;
    } result_t;

    // Additive round constants, one per round
    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Nonlinear function of the round group
    function automatic logic [31:0] round_f(
        input logic [1:0]  grp,
        input logic [31:0] b,
        input logic [31:0] c,
        input logic [31:0] d
    );
        logic [31:0] f;
        case (grp)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    // Message word used by a round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] j;
        logic [3:0] idx;
        j = rnd[3:0];
        case (rnd[5:4])
            2'd0:    idx = j;
            2'd1:    idx = j * 4'd5 + 4'd1;
            2'd2:    idx = j * 4'd3 + 4'd5;
            default: idx = j * 4'd7;
        endcase
        return idx;
    endfunction

    // Left rotate amount of a round
    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'h0:    s = 5'd7;
            4'h1:    s = 5'd12;
            4'h2:    s = 5'd17;
            4'h3:    s = 5'd22;
            4'h4:    s = 5'd5;
            4'h5:    s = 5'd9;
            4'h6:    s = 5'd14;
            4'h7:    s = 5'd20;
            4'h8:    s = 5'd4;
            4'h9:    s = 5'd11;
            4'ha:    s = 5'd16;
            4'hb:    s = 5'd23;
            4'hc:    s = 5'd6;
            4'hd:    s = 5'd10;
            4'he:    s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

endpackage
`default_nettype wire

// File: rtl/md5bc_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5bc_stream_if
// Valid/ready channel carrying one request or result payload.
// ----------------------------------------------------------------------------
interface md5bc_stream_if #(
    parameter type payload_t = logic [0:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/md5_block_compress_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a block-completing request passes through a setup state, 64 rounds
//   on the single round unit at one round per cycle, and a feed-forward state.
// Flow: load and buffered message requests are accepted while idle; no new request
//   is taken until a started block has written its result to the output register.
// Reset: chaining value to the MD5 IV, word counter and round registers to zero;
//   the message buffer is not cleared.
// ----------------------------------------------------------------------------
// md5_block_compress_unit
// MD5 compression engine: buffers message words, runs 64 rounds through one
// shared round unit and emits the updated chaining value.
// ----------------------------------------------------------------------------
module md5_block_compress_unit (
    input  wire                    clk,
    input  wire                    rst_n,
    md5bc_stream_if.sink           item,
    md5bc_stream_if.source         result
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PREP  = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        zero_blk_reg, zero_blk_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] msg_buf_reg [16];
    logic [31:0] km_reg;
    md5bc_pkg::result_t out_data_reg;

    md5bc_pkg::item_t req;
    logic        req_acc;
    logic        out_free;
    logic [5:0]  km_rnd;
    logic [31:0] m_word;
    logic [31:0] km_sum;
    logic [31:0] mix;
    logic [31:0] new_b;
    logic [31:0] sum_a, sum_b, sum_c, sum_d;

    assign req     = item.payload;
    assign item.ready = (state_reg == ST_IDLE);
    assign req_acc = item.valid && (state_reg == ST_IDLE);

    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;
    assign out_free       = !out_valid_reg || result.ready;

    // Fetch the message word and constant for the next round
    assign km_rnd = (state_reg == ST_PREP) ? 6'd0 : rnd_reg + 6'd1;
    assign m_word = zero_blk_reg ? 32'd0 : msg_buf_reg[md5bc_pkg::msg_index(km_rnd)];
    assign km_sum = md5bc_pkg::ROUND_K[km_rnd] + m_word;

    // Shared round unit
    assign mix   = a_reg + md5bc_pkg::round_f(rnd_reg[5:4], b_reg, c_reg, d_reg) + km_reg;
    assign new_b = b_reg + md5bc_pkg::rotl32(mix, md5bc_pkg::rot_amount(rnd_reg));

    // Feed-forward sums
    assign sum_a = chain_reg[0] + a_reg;
    assign sum_b = chain_reg[1] + b_reg;
    assign sum_c = chain_reg[2] + c_reg;
    assign sum_d = chain_reg[3] + d_reg;

    // Sequencer and next-state logic
    always_comb
    begin
        state_next     = state_reg;
        rnd_next       = rnd_reg;
        cnt_next       = cnt_reg;
        zero_blk_next  = zero_blk_reg;
        out_valid_next = out_valid_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        for (int k = 0; k < 4; k++)
        begin
            chain_next[k] = chain_reg[k];
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    case (req.func)
                        md5bc_pkg::FUNC_LOAD:
                        begin
                            chain_next[req.word_slot] = req.word;
                        end
                        md5bc_pkg::FUNC_WORD:
                        begin
                            cnt_next = cnt_reg + 4'd1;
                            if (cnt_reg == 4'd15)
                            begin
                                zero_blk_next = 1'b0;
                                state_next    = ST_PREP;
                            end
                        end
                        md5bc_pkg::FUNC_ZERO:
                        begin
                            cnt_next      = 4'd0;
                            zero_blk_next = 1'b1;
                            state_next    = ST_PREP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PREP:
            begin
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                rnd_next   = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                a_next   = d_reg;
                b_next   = new_b;
                c_next   = b_reg;
                d_next   = c_reg;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    chain_next[0]  = sum_a;
                    chain_next[1]  = sum_b;
                    chain_next[2]  = sum_c;
                    chain_next[3]  = sum_d;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rnd_reg       <= 6'd0;
            cnt_reg       <= 4'd0;
            zero_blk_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            a_reg         <= 32'd0;
            b_reg         <= 32'd0;
            c_reg         <= 32'd0;
            d_reg         <= 32'd0;
            chain_reg[0]  <= md5bc_pkg::IV_A;
            chain_reg[1]  <= md5bc_pkg::IV_B;
            chain_reg[2]  <= md5bc_pkg::IV_C;
            chain_reg[3]  <= md5bc_pkg::IV_D;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_reg       <= rnd_next;
            cnt_reg       <= cnt_next;
            zero_blk_reg  <= zero_blk_next;
            out_valid_reg <= out_valid_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            d_reg         <= d_next;
            for (int k = 0; k < 4; k++)
            begin
                chain_reg[k] <= chain_next[k];
            end
        end
    end

    // Payload registers: message buffer, prefetched K+M, output data
    always_ff @(posedge clk)
    begin
        if (req_acc && req.func == md5bc_pkg::FUNC_WORD)
        begin
            msg_buf_reg[cnt_reg] <= req.word;
        end
        if (state_reg == ST_PREP || state_reg == ST_ROUND)
        begin
            km_reg <= km_sum;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_data_reg.digest_low  <= {sum_b, sum_a};
            out_data_reg.digest_high <= {sum_d, sum_c};
        end
    end

    // Checks
    a_prep_to_round: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PREP |=> state_reg == ST_ROUND && rnd_reg == 6'd0)
        else $error("setup cycle did not start round zero");

    a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND && rnd_reg == 6'd63 |=> state_reg == ST_DONE)
        else $error("round sequence did not end after 64 rounds");

    a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_free |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished block did not reach the output register");

    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req.func == md5bc_pkg::FUNC_ZERO |=>
            cnt_reg == 4'd0 && zero_blk_reg && state_reg == ST_PREP)
        else $error("zero block request did not reset the word counter");

endmodule
`default_nettype wire
